>>> rtl/ortt_pkg.sv
// Shared types and constants for the owner range tracking table.
// Holds the operation codes, the sequencer state type and the entry layout.
// Depends on nothing.
`default_nettype none

package ortt_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int ADDR_BITS = 48;

    localparam int OP_W     = 3;
    localparam int OWNER_W  = 32;
    localparam int BASE_W   = ADDR_BITS;
    localparam int LEN_W    = ADDR_BITS + 1;
    localparam int TAG_W    = 52;
    localparam int HANDLE_W = 48;
    localparam int END_W    = ADDR_BITS + 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [END_W-1:0] SPACE    = END_W'(1) << ADDR_BITS;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND_OWNER = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_OVL   = 3'd3;
    localparam logic [OP_W-1:0] OP_PARTIAL    = 3'd4;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [BASE_W-1:0]   base;
        logic [LEN_W-1:0]    length;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

endpackage

`default_nettype wire

>>> rtl/owner_range_tracking_table.sv
// Owner range tracking table: 64-slot range store with add, remove and lookups.
// Entries sit in a one-read, one-write memory; valid bits are flip-flops.
// Depends on ortt_pkg.
//
// Scanning requests return their result when the scan ends at the first matching
// slot or at the last slot; rejected requests (unused code, or for the overlap
// lookups an empty range or a range past the address space) answer in the next cycle.
// One request at a time; busy stays high during the scan, which reads one memory
// slot per cycle through a registered read. Reset clears all valid bits at once;
// no clearing pass. The receiver cannot stall.
`default_nettype none

module owner_range_tracking_table
    import ortt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [OWNER_W-1:0]  i_owner_id,
    input  wire logic [BASE_W-1:0]   i_base_addr,
    input  wire logic [LEN_W-1:0]    i_length,
    input  wire logic [TAG_W-1:0]    i_tag_in,
    input  wire logic [HANDLE_W-1:0] i_handle_in,
    output logic                     o_strobe,
    output logic                     o_hit,
    output logic [BASE_W-1:0]        o_found_base,
    output logic [LEN_W-1:0]         o_found_length,
    output logic [TAG_W-1:0]         o_found_tag,
    output logic [HANDLE_W-1:0]      o_found_handle
);

    // Sequencer and scan control
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_issue, n_issue;
    logic                r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0]    r_ev_idx, n_ev_idx;
    logic [ENTRIES-1:0]  r_valid, n_valid;

    // Latched request
    logic [OP_W-1:0]     r_op;
    logic [OWNER_W-1:0]  r_owner;
    logic [BASE_W-1:0]   r_base;
    logic [LEN_W-1:0]    r_len;
    logic [TAG_W-1:0]    r_tag;
    logic [HANDLE_W-1:0] r_handle;
    logic [END_W-1:0]    r_req_end;

    // Result registers
    logic                r_strobe, n_strobe;
    logic                r_hit, n_hit;
    logic [BASE_W-1:0]   r_fbase, n_fbase;
    logic [LEN_W-1:0]    r_flen, n_flen;
    logic [TAG_W-1:0]    r_ftag, n_ftag;
    logic [HANDLE_W-1:0] r_fhandle, n_fhandle;

    // Entry memory
    t_entry              mem [ENTRIES];
    t_entry              r_rd;
    logic                mem_we;
    t_entry              mem_wdata;

    logic                accept;
    logic [END_W-1:0]    in_req_end;
    logic                in_ovl_op;
    logic                in_imm;
    logic                in_imm_hit;

    logic                ev_valid;
    logic                ev_own;
    logic [END_W-1:0]    ev_base;
    logic [END_W-1:0]    ev_end;
    logic                ev_ovl;
    logic                ev_part;
    logic                ev_match;
    logic                ev_finish;

    assign accept     = start && (r_state == S_IDLE);
    assign in_req_end = END_W'(i_base_addr) + END_W'(i_length);
    assign in_ovl_op  = (i_operation == OP_FIND_OVL) || (i_operation == OP_PARTIAL);

    always_comb begin
        in_imm     = 1'b0;
        in_imm_hit = 1'b0;
        if (!(i_operation inside {OP_ADD, OP_REMOVE, OP_FIND_OWNER,
                                  OP_FIND_OVL, OP_PARTIAL})) begin
            in_imm = 1'b1;
        end else if (in_ovl_op && (i_length == '0)) begin
            in_imm = 1'b1;
        end else if (in_ovl_op && (in_req_end > SPACE)) begin
            // out of the address space: partial overlap by definition
            in_imm     = 1'b1;
            in_imm_hit = (i_operation == OP_PARTIAL);
        end
    end

    // Compare unit for the slot whose read data just arrived
    assign ev_valid = r_valid[r_ev_idx];
    assign ev_own   = ev_valid && (r_rd.owner == r_owner);
    assign ev_base  = END_W'(r_rd.base);
    assign ev_end   = END_W'(r_rd.base) + END_W'(r_rd.length);
    assign ev_ovl   = (END_W'(r_base) < ev_end) && (r_req_end > ev_base);
    assign ev_part  = (ev_base < END_W'(r_base)) || (ev_end > r_req_end);

    always_comb begin
        case (r_op)
            OP_ADD:        ev_match = !ev_valid;
            OP_REMOVE:     ev_match = ev_own && (r_rd.base == r_base);
            OP_FIND_OWNER: ev_match = ev_own;
            OP_FIND_OVL:   ev_match = ev_own && ev_ovl;
            OP_PARTIAL:    ev_match = ev_own && ev_ovl && ev_part;
            default:       ev_match = 1'b0;
        endcase
    end

    assign ev_finish = r_ev_vld && (ev_match || (r_ev_idx == LAST_IDX));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !in_imm) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (ev_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Scan control, table updates and results
    always_comb begin
        n_idx     = r_idx;
        n_issue   = r_issue;
        n_ev_vld  = 1'b0;
        n_ev_idx  = r_idx;
        n_valid   = r_valid;
        n_strobe  = 1'b0;
        n_hit     = r_hit;
        n_fbase   = r_fbase;
        n_flen    = r_flen;
        n_ftag    = r_ftag;
        n_fhandle = r_fhandle;
        mem_we    = 1'b0;
        mem_wdata = '{owner: r_owner, base: r_base, length: r_len,
                      tag: r_tag, handle: r_handle};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_issue = 1'b1;
                    if (in_imm) begin
                        n_strobe  = 1'b1;
                        n_hit     = in_imm_hit;
                        n_fbase   = '0;
                        n_flen    = '0;
                        n_ftag    = '0;
                        n_fhandle = '0;
                    end
                end
            end
            S_SCAN: begin
                // advance the read pointer; the slot read now is checked next cycle
                n_ev_vld = r_issue;
                if (r_issue) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                if (ev_finish) begin
                    n_ev_vld  = 1'b0;
                    n_issue   = 1'b0;
                    n_strobe  = 1'b1;
                    n_hit     = ev_match;
                    n_fbase   = '0;
                    n_flen    = '0;
                    n_ftag    = '0;
                    n_fhandle = '0;
                    if (ev_match) begin
                        case (r_op)
                            OP_ADD: begin
                                mem_we            = 1'b1;
                                n_valid[r_ev_idx] = 1'b1;
                            end
                            OP_REMOVE: begin
                                n_valid[r_ev_idx] = 1'b0;
                                n_fbase   = r_rd.base;
                                n_flen    = r_rd.length;
                                n_ftag    = r_rd.tag;
                                n_fhandle = r_rd.handle;
                            end
                            OP_FIND_OWNER, OP_FIND_OVL: begin
                                n_fbase = r_rd.base;
                                n_flen  = r_rd.length;
                                n_ftag  = r_rd.tag;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_issue  <= 1'b0;
            r_ev_vld <= 1'b0;
            r_ev_idx <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_issue  <= n_issue;
            r_ev_vld <= n_ev_vld;
            r_ev_idx <= n_ev_idx;
            r_valid  <= n_valid;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_owner   <= i_owner_id;
            r_base    <= i_base_addr;
            r_len     <= i_length;
            r_tag     <= i_tag_in;
            r_handle  <= i_handle_in;
            r_req_end <= in_req_end;
        end
        r_hit     <= n_hit;
        r_fbase   <= n_fbase;
        r_flen    <= n_flen;
        r_ftag    <= n_ftag;
        r_fhandle <= n_fhandle;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_ev_idx] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_idx];
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_hit          = r_hit;
    assign o_found_base   = r_fbase;
    assign o_found_length = r_flen;
    assign o_found_tag    = r_ftag;
    assign o_found_handle = r_fhandle;

`ifndef NO_ASSERTIONS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while scan still running");

    a_bad_op_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation > OP_PARTIAL)) |=> (o_strobe && !o_hit))
        else $error("unused operation code not answered at once");

    a_add_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && ev_finish && ev_match && r_op == OP_ADD)
        |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("add did not occupy exactly one slot");

    a_add_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit && r_op == OP_ADD) |-> (&r_valid))
        else $error("add rejected with a free slot");

    a_eval_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == S_SCAN))
        else $error("slot check pending outside a scan");
`endif

endmodule

`default_nettype wire
